// File: hw/rtl/tdbt_pkg.sv
// shared types and constants for the tone divider and beep timer
package tdbt_pkg;

    localparam int CLK_W   = 28;
    localparam int HZ_W    = 16;
    localparam int DUR_W   = 32;
    localparam int TOP_W   = 16;
    localparam int DINT_W  = 8;
    localparam int DFRAC_W = 4;
    localparam int DUTY_W  = 15;
    localparam int QUOT_W  = CLK_W;
    localparam int DEN_W   = HZ_W + 1;
    localparam int CNT_W   = $clog2(QUOT_W);
    localparam int SHIFT_W = 5;
    localparam int DATA_W  = 48;
    localparam int OUT_USED_W = 1 + TOP_W + DINT_W + DFRAC_W + DUTY_W;

    localparam logic [CLK_W-1:0]   CLOCK_RESET   = CLK_W'(125000000);
    localparam logic [SHIFT_W-1:0] MAX_SHIFT     = SHIFT_W'(16);
    localparam logic [SHIFT_W-1:0] MIN_SHIFT     = SHIFT_W'(4);
    localparam logic [TOP_W-1:0]   SLOW_TOP      = '1;
    localparam logic [DINT_W-1:0]  SLOW_DIV_INT  = '1;
    localparam logic [DFRAC_W-1:0] SLOW_DIV_FRAC = '1;
    localparam int                 MIN_DIV_BITS  = 7;
    localparam int                 SAT_BIT       = 24;

    localparam logic ACT_BEEP = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SHIFT,
        S_EMIT
    } t_state;

endpackage

// File: hw/rtl/tdbt_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module tdbt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tdbt_pkg::QUOT_W-1:0] i_dividend,
    input  logic [tdbt_pkg::DEN_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [tdbt_pkg::QUOT_W-1:0] o_quot
);
    import tdbt_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [QUOT_W-1:0] r_quot;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;
    logic [DEN_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_quot[QUOT_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("done without a finished division");
    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != '0 |=> r_busy)
        else $error("division ended early");
`endif

endmodule

// File: hw/rtl/tone_divider_and_beep_timer.sv
// top level: beep command decode, divisor selection and millisecond countdown
// flow: a tick beat, or a beep beat with zero frequency, goes straight to the result;
// any other beep beat runs the 28-step serial divider, then, unless the quotient
// saturates, a shift search of up to 12 steps
// ordering: one beat at a time, no new input beat until the result is registered
// reset: synchronous active low; tone off, countdown and held settings zero
module tone_divider_and_beep_timer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tdbt_pkg::CLK_W-1:0]  i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tone_hz[15:0], duration_ms[47:16]
    input  logic [tdbt_pkg::DATA_W-1:0] s_axis_tdata,
    // action
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tone_on[0], wrap_top[16:1], div_int[24:17], div_frac[28:25], duty_level[43:29]
    output logic [tdbt_pkg::DATA_W-1:0] m_axis_tdata
);
    import tdbt_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [CLK_W-1:0]   r_clk_hz;
    logic [DUR_W-1:0]   r_remaining;
    logic [DUR_W-1:0]   r_dur;
    logic               r_active;
    logic [TOP_W-1:0]   r_top;
    logic [DINT_W-1:0]  r_dint;
    logic [DFRAC_W-1:0] r_dfrac;
    logic [SHIFT_W-1:0] r_shift;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_data;

    logic [HZ_W-1:0]    w_hz;
    logic [DUR_W-1:0]   w_dur;
    logic               w_accept;
    logic               w_emit_ok;
    logic               w_div_start;
    logic               w_div_done;
    logic [QUOT_W-1:0]  w_quot;
    logic               w_sat;
    logic [QUOT_W-1:0]  w_q_sh;
    logic [QUOT_W-1:0]  w_q_fr;
    logic               w_small;
    logic               w_step;
    logic [TOP_W:0]     w_top_full;
    logic               w_ld_slow_now;
    logic               w_ld_slow_div;
    logic               w_ld_shift;
    logic               w_tick;

    assign w_hz  = s_axis_tdata[HZ_W-1:0];
    assign w_dur = s_axis_tdata[HZ_W +: DUR_W];

    tdbt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_clk_hz),
        .i_divisor  ({w_hz, 1'b0}),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_sat      = (w_quot[QUOT_W-1:SAT_BIT] != '0);
        w_q_sh     = w_quot >> r_shift;
        w_q_fr     = w_quot >> (r_shift - MIN_SHIFT);
        w_small    = (w_q_sh[QUOT_W-1:MIN_DIV_BITS] == '0);
        w_step     = (r_shift > MIN_SHIFT) && w_small;
        w_top_full = ((TOP_W + 1)'(1) << r_shift) - (TOP_W + 1)'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == ACT_TICK || w_hz == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = w_sat ? S_EMIT : S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (!w_step) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_ld_slow_now = 1'b0;
        w_ld_slow_div = 1'b0;
        w_ld_shift    = 1'b0;
        w_tick        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    w_tick        = (s_axis_tuser == ACT_TICK);
                    w_ld_slow_now = (s_axis_tuser == ACT_BEEP) && (w_hz == '0);
                    w_div_start   = (s_axis_tuser == ACT_BEEP) && (w_hz != '0);
                end
            end
            S_DIV:   w_ld_slow_div = w_div_done && w_sat;
            S_SHIFT: w_ld_shift    = !w_step;
            S_EMIT:  ;
            default: ;
        endcase
    end

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_emit_ok = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clk_hz    <= CLOCK_RESET;
            r_remaining <= '0;
            r_active    <= 1'b0;
            r_top       <= '0;
            r_dint      <= '0;
            r_dfrac     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_wdata;
            end
            if (w_tick && r_remaining != '0) begin
                r_remaining <= r_remaining - DUR_W'(1);
                if (r_remaining == DUR_W'(1)) begin
                    r_active <= 1'b0;
                end
            end
            if (w_ld_slow_now) begin
                r_top       <= SLOW_TOP;
                r_dint      <= SLOW_DIV_INT;
                r_dfrac     <= SLOW_DIV_FRAC;
                r_active    <= 1'b1;
                r_remaining <= w_dur;
            end
            if (w_ld_slow_div) begin
                r_top       <= SLOW_TOP;
                r_dint      <= SLOW_DIV_INT;
                r_dfrac     <= SLOW_DIV_FRAC;
                r_active    <= 1'b1;
                r_remaining <= r_dur;
            end
            if (w_ld_shift) begin
                r_top       <= w_top_full[TOP_W-1:0];
                r_dint      <= w_q_sh[DINT_W-1:0];
                r_dfrac     <= w_q_fr[DFRAC_W-1:0];
                r_active    <= 1'b1;
                r_remaining <= r_dur;
            end
            if (r_state == S_EMIT && w_emit_ok) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_dur <= w_dur;
        end
        if (w_div_done) begin
            r_shift <= MAX_SHIFT;
        end else if (r_state == S_SHIFT && w_step) begin
            r_shift <= r_shift - SHIFT_W'(1);
        end
        if (r_state == S_EMIT && w_emit_ok) begin
            r_out_data <= {(DATA_W - OUT_USED_W)'(0), r_top[TOP_W-1:1], r_dfrac, r_dint,
                           r_top, r_active};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT |-> r_shift >= MIN_SHIFT && r_shift <= MAX_SHIFT)
        else $error("shift search out of range");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("accepted beat did not start work");
    a_off_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_remaining == '0)
        else $error("countdown running with tone off");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && w_emit_ok |=> r_out_valid)
        else $error("result not presented");
`endif

endmodule

// File: tb/tb_tone_divider_and_beep_timer.sv
// testbench for the tone divider and beep timer: directed and random beats checked against a predictor
`timescale 1ns / 100ps

module tb_tone_divider_and_beep_timer;
    import tdbt_pkg::*;

    typedef struct packed {
        logic               tone_on;
        logic [TOP_W-1:0]   wrap_top;
        logic [DINT_W-1:0]  div_int;
        logic [DFRAC_W-1:0] div_frac;
        logic [DUTY_W-1:0]  duty_level;
    } t_buzzer_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CLK_W-1:0]    i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;
    logic                s_axis_tuser = ACT_TICK;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;

    // predictor state
    logic [CLK_W-1:0]    core_hz = CLOCK_RESET;
    logic [DUR_W-1:0]    left_ms = '0;
    logic                sounding = 1'b0;
    logic [TOP_W-1:0]    top_held = '0;
    logic [DINT_W-1:0]   dint_held = '0;
    logic [DFRAC_W-1:0]  dfrac_held = '0;

    t_buzzer_result      predicted_buzzer_q[$];
    t_buzzer_result      want_res;
    int                  errors = 0;
    int                  beats_sent = 0;
    int                  beeps_sent = 0;
    int                  ticks_sent = 0;
    int                  results_seen = 0;
    int                  clock_writes = 0;
    bit                  calm = 1'b0;
    bit                  gappy = 1'b1;
    int                  stall_left = 0;
    int                  quiet_left = 0;

    tone_divider_and_beep_timer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_buzzer_result predict_buzzer(logic act, logic [HZ_W-1:0] hz,
                                                      logic [DUR_W-1:0] dur);
        logic [31:0]    quot;
        int             shift;
        t_buzzer_result r;
        if (act == ACT_BEEP) begin
            if (hz == '0) begin
                quot = 32'd1 << SAT_BIT;
            end else begin
                quot = 32'(core_hz) / (32'(hz) << 1);
            end
            if (quot >= (32'd1 << SAT_BIT)) begin
                top_held   = SLOW_TOP;
                dint_held  = SLOW_DIV_INT;
                dfrac_held = SLOW_DIV_FRAC;
            end else begin
                shift = int'(MAX_SHIFT);
                while (shift > int'(MIN_SHIFT) && (quot >> shift) < (32'd1 << MIN_DIV_BITS))
                    shift--;
                top_held   = TOP_W'((32'd1 << shift) - 1);
                dint_held  = DINT_W'(quot >> shift);
                dfrac_held = DFRAC_W'(quot >> (shift - DFRAC_W));
            end
            sounding = 1'b1;
            left_ms  = dur;
        end else if (left_ms != '0) begin
            left_ms--;
            if (left_ms == '0) begin
                sounding = 1'b0;
            end
        end
        r.tone_on    = sounding;
        r.wrap_top   = top_held;
        r.div_int    = dint_held;
        r.div_frac   = dfrac_held;
        r.duty_level = DUTY_W'(top_held >> 1);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            errors++;
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endfunction

    // result beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_buzzer_q.size() == 0) begin
                errors++;
                $display("%0t result beat with nothing expected: expected none, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want_res = predicted_buzzer_q.pop_front();
                results_seen++;
                check_field("tone_on", 32'(want_res.tone_on), 32'(m_axis_tdata[0]));
                check_field("wrap_top", 32'(want_res.wrap_top), 32'(m_axis_tdata[16:1]));
                check_field("div_int", 32'(want_res.div_int), 32'(m_axis_tdata[24:17]));
                check_field("div_frac", 32'(want_res.div_frac), 32'(m_axis_tdata[28:25]));
                check_field("duty_level", 32'(want_res.duty_level),
                            32'(m_axis_tdata[43:29]));
                check_field("padding", 32'd0, 32'(m_axis_tdata[DATA_W-1:44]));
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                quiet_left = $urandom_range(20, 200);
        end else if (quiet_left > 0) begin
            quiet_left--;
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_beat(logic act, logic [HZ_W-1:0] hz, logic [DUR_W-1:0] dur);
        if (!calm && gappy && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {dur, hz};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted_buzzer_q.push_back(predict_buzzer(act, hz, dur));
        beats_sent++;
        if (act == ACT_BEEP) beeps_sent++;
        else ticks_sent++;
    endtask

    task automatic send_tick();
        send_beat(ACT_TICK, HZ_W'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (predicted_buzzer_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_core_clock(logic [CLK_W-1:0] hz);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= hz;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        core_hz = hz;
        clock_writes++;
    endtask

    function automatic logic [HZ_W-1:0] pick_tone();
        case ($urandom_range(0, 4))
            0: return ($urandom_range(0, 7) == 0) ? '0 : HZ_W'($urandom);
            1: return HZ_W'($urandom_range(1, 16));
            2: return HZ_W'($urandom_range(17, 400));
            3: return HZ_W'($urandom_range(400, 8000));
            default: return HZ_W'($urandom);
        endcase
    endfunction

    task automatic test_reset_state();
        send_tick();
    endtask

    task automatic test_divisor_extremes();
        send_beat(ACT_BEEP, 16'd0, 32'd0);
        send_beat(ACT_BEEP, 16'd1, 32'd0);
        send_beat(ACT_BEEP, 16'd3, 32'd0);
        send_beat(ACT_BEEP, 16'd4, 32'd0);
        send_beat(ACT_BEEP, 16'd1000, 32'd0);
        send_beat(ACT_BEEP, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_countdown();
        send_beat(ACT_BEEP, 16'd440, 32'd0);
        send_tick();
        send_tick();
        send_beat(ACT_BEEP, 16'd880, 32'd2);
        repeat (3) send_tick();
        send_beat(ACT_BEEP, 16'd2000, 32'd5);
        send_tick();
        wait_drained();
        send_beat(ACT_BEEP, 16'd50, 32'd1);
        send_tick();
    endtask

    task automatic test_clock_settings();
        write_core_clock('0);
        send_beat(ACT_BEEP, 16'd1000, 32'd0);
        write_core_clock('1);
        send_beat(ACT_BEEP, 16'd1, 32'd0);
        send_beat(ACT_BEEP, 16'hFFFF, 32'd0);
        write_core_clock(CLK_W'(1000000));
        send_beat(ACT_BEEP, 16'd3, 32'd0);
        write_core_clock(CLK_W'(250000000));
        send_beat(ACT_BEEP, 16'd7, 32'd0);
        send_beat(ACT_BEEP, 16'd8, 32'd0);
        write_core_clock(CLOCK_RESET);
    endtask

    task automatic test_random_traffic();
        logic [CLK_W-1:0] clocks[5];
        int               target;
        int               n;
        clocks[0] = CLOCK_RESET;
        clocks[1] = CLK_W'(1000000);
        clocks[2] = CLK_W'(250000000);
        clocks[3] = CLK_W'($urandom_range(1000000, 250000000));
        clocks[4] = CLK_W'($urandom);
        for (int p = 0; p < 5; p++) begin
            write_core_clock(clocks[p]);
            calm = (p == 4);
            target = beats_sent + 380;
            while (beats_sent < target) begin
                gappy = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 9))
                    7: begin
                        send_beat(ACT_BEEP, pick_tone(), $urandom);
                        repeat ($urandom_range(0, 3)) send_tick();
                    end
                    8: begin
                        send_beat(ACT_BEEP, pick_tone(), 32'd0);
                        repeat ($urandom_range(0, 3)) send_tick();
                    end
                    9: begin
                        send_beat(logic'($urandom_range(0, 1)), HZ_W'($urandom), $urandom);
                    end
                    default: begin
                        n = $urandom_range(1, 12);
                        send_beat(ACT_BEEP, pick_tone(), DUR_W'(n));
                        repeat (n + $urandom_range(0, 2)) send_tick();
                    end
                endcase
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_divisor_extremes();
        test_countdown();
        test_clock_settings();
        test_random_traffic();
        wait_drained();
        repeat (60) @(posedge i_clk);
        $display("covered %0d beats (%0d beeps, %0d ticks) across %0d core clock writes",
                 beats_sent, beeps_sent, ticks_sent, clock_writes);
        $display("%0d result beats checked, %0d field mismatches", results_seen, errors);
        if (errors == 0) begin
            $display("tone_divider_and_beep_timer regression: pass");
        end else begin
            $display("tone_divider_and_beep_timer regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", predicted_buzzer_q.size());
        $display("tone_divider_and_beep_timer regression: fail");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tdbt_pkg.sv
hw/rtl/tdbt_div.sv
hw/rtl/tone_divider_and_beep_timer.sv
tb/tb_tone_divider_and_beep_timer.sv
